// ----- design/mccs_pkg.sv -----
`timescale 1ns / 1ps

package mccs_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int SUBSET_W     = MAX_VERTICES;
    localparam int VIDX_W       = 4;
    localparam int CNT_W        = 5;
    localparam int COST_W       = 5;

    localparam logic [COST_W-1:0] COST_ONE  = COST_W'(1);
    localparam logic [COST_W-1:0] UNBOUNDED = COST_W'(31);

    localparam logic [CNT_W-1:0] VCNT_RESET = CNT_W'(MAX_VERTICES);

    // request kinds carried on tuser
    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MARK,
        S_SPLIT_RD,
        S_SPLIT_CHK,
        S_SPLIT_RUN,
        S_SPLIT_DRAIN,
        S_SPLIT_WR,
        S_ANS_RD,
        S_ANS_LD
    } t_state;

    typedef struct packed {
        logic i_init;
        logic i_next;
        logic mark_we;
        logic best_init;
        logic split_issue;
        logic best_wr;
        logic rd_full;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic i_is_full;
        logic cost_is_one;
        logic sub_zero;
        logic out_free;
    } t_dp_status;

endpackage

// ----- design/min_clique_cover_subset_dp.sv -----
`timescale 1ns / 1ps
// edge word: the block is ready again on the next cycle
// solve word: clique marks for every subset, a cost read and check per subset, a split search,
//   drain and best-cost write for each subset that is no clique, then an answer read and load
// the answer sits in an output register until taken; no word is accepted during a solve
// reset (synchronous, active low) clears adjacency rows, vertex count to 16 and all control;
// the subset cost memory is not cleared, every entry is written before a solve reads it

module min_clique_cover_subset_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // edge / solve words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // vertex_a[3:0], vertex_b[7:4]
    input  logic                                s_axis_tuser,   // req_type[0]
    // answer words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // min_cliques[4:0], zeros[7:5]
    // vertex count register
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mccs_pkg::CNT_W-1:0]          i_cfg_data
);

    mccs_pkg::t_dp_cmd    w_cmd;
    mccs_pkg::t_dp_status w_status;
    logic                 w_in_acc;
    logic                 w_solve_start;
    logic                 w_edge_we;
    logic [mccs_pkg::COST_W-1:0] w_min_cliques;

    // a word is taken only while the controller is idle
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_solve_start = w_in_acc && (s_axis_tuser == mccs_pkg::REQ_SOLVE);
    assign w_edge_we     = w_in_acc && (s_axis_tuser == mccs_pkg::REQ_EDGE);

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    mccs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_solve_start (w_solve_start),
        .i_status      (w_status),
        .o_in_ready    (s_axis_tready),
        .o_cmd         (w_cmd)
    );

    // adjacency rows, cost memory, split search and answer register
    mccs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_edge_we     (w_edge_we),
        .i_vertex_a    (s_axis_tdata[3:0]),
        .i_vertex_b    (s_axis_tdata[7:4]),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_min_cliques (w_min_cliques)
    );

    assign m_axis_tdata = {3'b000, w_min_cliques};

`ifndef ASSERT_OFF
    // a new answer appears only from an answer load
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.out_load))
        else $error("answer valid without load");

    // a loaded answer lies between one and the vertex maximum
    a_answer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[4:0] <= 5'd16))
        else $error("answer out of range");

    // no word is taken while the memory is in use by a solve
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_cmd.mark_we && !w_cmd.split_issue && !w_cmd.best_wr)
        else $error("input ready during solve");
`endif

endmodule

// ----- design/mccs_ctrl.sv -----
`timescale 1ns / 1ps

module mccs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_solve_start,
    input  mccs_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output mccs_pkg::t_dp_cmd    o_cmd
);

    mccs_pkg::t_state r_state;
    mccs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mccs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mccs_pkg::S_IDLE: begin
                if (i_solve_start) n_state = mccs_pkg::S_MARK;
            end
            mccs_pkg::S_MARK: begin
                if (i_status.i_is_full) n_state = mccs_pkg::S_SPLIT_RD;
            end
            mccs_pkg::S_SPLIT_RD: begin
                n_state = mccs_pkg::S_SPLIT_CHK;
            end
            mccs_pkg::S_SPLIT_CHK: begin
                if (!i_status.cost_is_one) begin
                    n_state = mccs_pkg::S_SPLIT_RUN;
                end else if (i_status.i_is_full) begin
                    n_state = mccs_pkg::S_ANS_RD;
                end else begin
                    n_state = mccs_pkg::S_SPLIT_RD;
                end
            end
            mccs_pkg::S_SPLIT_RUN: begin
                if (i_status.sub_zero) n_state = mccs_pkg::S_SPLIT_DRAIN;
            end
            mccs_pkg::S_SPLIT_DRAIN: begin
                n_state = mccs_pkg::S_SPLIT_WR;
            end
            mccs_pkg::S_SPLIT_WR: begin
                n_state = i_status.i_is_full ? mccs_pkg::S_ANS_RD : mccs_pkg::S_SPLIT_RD;
            end
            mccs_pkg::S_ANS_RD: begin
                n_state = mccs_pkg::S_ANS_LD;
            end
            mccs_pkg::S_ANS_LD: begin
                if (i_status.out_free) n_state = mccs_pkg::S_IDLE;
            end
            default: begin
                n_state = mccs_pkg::S_IDLE;
            end
        endcase
    end

    // input side is open only while idle
    assign o_in_ready = (r_state == mccs_pkg::S_IDLE);

    // outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            mccs_pkg::S_IDLE: begin
                o_cmd.i_init = i_solve_start;
            end
            mccs_pkg::S_MARK: begin
                o_cmd.mark_we = 1'b1;
                o_cmd.i_init  = i_status.i_is_full;
                o_cmd.i_next  = !i_status.i_is_full;
            end
            mccs_pkg::S_SPLIT_RD: begin
                o_cmd = '0;
            end
            mccs_pkg::S_SPLIT_CHK: begin
                o_cmd.best_init = !i_status.cost_is_one;
                o_cmd.i_next    = i_status.cost_is_one && !i_status.i_is_full;
            end
            mccs_pkg::S_SPLIT_RUN: begin
                o_cmd.split_issue = 1'b1;
            end
            mccs_pkg::S_SPLIT_DRAIN: begin
                o_cmd = '0;
            end
            mccs_pkg::S_SPLIT_WR: begin
                o_cmd.best_wr = 1'b1;
                o_cmd.i_next  = !i_status.i_is_full;
            end
            mccs_pkg::S_ANS_RD: begin
                o_cmd.rd_full = 1'b1;
            end
            mccs_pkg::S_ANS_LD: begin
                o_cmd.rd_full  = 1'b1;
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/mccs_dp.sv -----
`timescale 1ns / 1ps

module mccs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mccs_pkg::t_dp_cmd                   i_cmd,
    output mccs_pkg::t_dp_status                o_status,
    input  logic                                i_edge_we,
    input  logic [mccs_pkg::VIDX_W-1:0]         i_vertex_a,
    input  logic [mccs_pkg::VIDX_W-1:0]         i_vertex_b,
    input  logic                                i_cfg_we,
    input  logic [mccs_pkg::CNT_W-1:0]          i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mccs_pkg::COST_W-1:0]         o_min_cliques
);

    logic [mccs_pkg::SUBSET_W-1:0] r_adj [mccs_pkg::MAX_VERTICES];
    logic [mccs_pkg::CNT_W-1:0]    r_vcnt;
    logic [mccs_pkg::SUBSET_W-1:0] r_i;
    logic [mccs_pkg::SUBSET_W-1:0] r_sub;
    logic [mccs_pkg::COST_W-1:0]   r_best;
    logic [mccs_pkg::COST_W-1:0]   r_rd_a;
    logic [mccs_pkg::COST_W-1:0]   r_rd_b;
    logic                          r_rd_vld;
    logic [mccs_pkg::COST_W-1:0]   r_out;
    logic                          r_out_vld;

    // subset cost store, no reset
    logic [mccs_pkg::COST_W-1:0] mem [2**mccs_pkg::SUBSET_W];

    logic [mccs_pkg::CNT_W-1:0]    w_n;
    logic [mccs_pkg::SUBSET_W:0]   w_pow;
    logic [mccs_pkg::SUBSET_W-1:0] w_full;
    logic [mccs_pkg::SUBSET_W-1:0] w_low;
    logic [mccs_pkg::SUBSET_W-1:0] w_rest;
    logic [mccs_pkg::SUBSET_W-1:0] w_j;
    logic [mccs_pkg::SUBSET_W-1:0] w_k;
    logic [mccs_pkg::SUBSET_W-1:0] w_raddr_a;
    logic                          w_clique;
    logic [mccs_pkg::COST_W:0]     w_sum;
    logic [mccs_pkg::COST_W-1:0]   w_sat;
    logic                          w_we;
    logic [mccs_pkg::COST_W-1:0]   w_wdata;

    // vertices in use, clamped to 1..max
    always_comb begin
        if (r_vcnt == '0) begin
            w_n = mccs_pkg::CNT_W'(1);
        end else if (r_vcnt > mccs_pkg::CNT_W'(mccs_pkg::MAX_VERTICES)) begin
            w_n = mccs_pkg::CNT_W'(mccs_pkg::MAX_VERTICES);
        end else begin
            w_n = r_vcnt;
        end
    end

    assign w_pow  = (mccs_pkg::SUBSET_W+1)'(1) << w_n;
    assign w_full = mccs_pkg::SUBSET_W'(w_pow - 1'b1);

    // split enumeration: side j always holds the lowest vertex of i
    assign w_low  = r_i & (~r_i + mccs_pkg::SUBSET_W'(1));
    assign w_rest = r_i ^ w_low;
    assign w_j    = w_low | r_sub;
    assign w_k    = r_i ^ w_j;

    // clique test of subset i against the adjacency rows
    always_comb begin
        w_clique = 1'b1;
        for (int v = 0; v < mccs_pkg::MAX_VERTICES; v++) begin
            if (r_i[v] && (((r_adj[v] | (mccs_pkg::SUBSET_W'(1) << v)) & r_i) != r_i)) begin
                w_clique = 1'b0;
            end
        end
    end

    assign w_sum = {1'b0, r_rd_a} + {1'b0, r_rd_b};
    assign w_sat = (w_sum >= (mccs_pkg::COST_W+1)'(mccs_pkg::UNBOUNDED)) ?
                   mccs_pkg::UNBOUNDED : w_sum[mccs_pkg::COST_W-1:0];

    assign w_we    = i_cmd.mark_we | i_cmd.best_wr;
    assign w_wdata = i_cmd.mark_we ? (w_clique ? mccs_pkg::COST_ONE : mccs_pkg::UNBOUNDED)
                                   : r_best;

    always_comb begin
        if (i_cmd.split_issue) begin
            w_raddr_a = w_j;
        end else if (i_cmd.rd_full) begin
            w_raddr_a = w_full;
        end else begin
            w_raddr_a = r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[r_i] <= w_wdata;
        r_rd_a <= mem[w_raddr_a];
        r_rd_b <= mem[w_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < mccs_pkg::MAX_VERTICES; r++) r_adj[r] <= '0;
            r_vcnt    <= mccs_pkg::VCNT_RESET;
            r_i       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                for (int r = 0; r < mccs_pkg::MAX_VERTICES; r++) r_adj[r] <= '0;
            end else if (i_edge_we && (i_vertex_a != i_vertex_b)
                         && (32'(i_vertex_a) < mccs_pkg::MAX_VERTICES)
                         && (32'(i_vertex_b) < mccs_pkg::MAX_VERTICES)) begin
                r_adj[i_vertex_a][i_vertex_b] <= 1'b1;
                r_adj[i_vertex_b][i_vertex_a] <= 1'b1;
            end
            if (i_cfg_we) r_vcnt <= i_cfg_data;
            if (i_cmd.i_init) begin
                r_i <= mccs_pkg::SUBSET_W'(1);
            end else if (i_cmd.i_next) begin
                r_i <= r_i + mccs_pkg::SUBSET_W'(1);
            end
            r_rd_vld <= i_cmd.split_issue;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.best_init) begin
            r_sub <= (w_rest - mccs_pkg::SUBSET_W'(1)) & w_rest;
        end else if (i_cmd.split_issue) begin
            r_sub <= (r_sub - mccs_pkg::SUBSET_W'(1)) & w_rest;
        end
        if (i_cmd.best_init) begin
            r_best <= r_rd_a;
        end else if (r_rd_vld && (w_sat < r_best)) begin
            r_best <= w_sat;
        end
        if (i_cmd.out_load) r_out <= r_rd_a;
    end

    assign o_status.i_is_full   = (r_i == w_full);
    assign o_status.cost_is_one = (r_rd_a == mccs_pkg::COST_ONE);
    assign o_status.sub_zero    = (r_sub == '0);
    assign o_status.out_free    = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_min_cliques = r_out;

endmodule

// ----- bench/mccs_cover_checker.sv -----
`timescale 1ns / 1ps

module mccs_cover_checker
    import mccs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [7:0]       i_in_data,    // vertex_a[3:0], vertex_b[7:4]
    input  logic             i_in_user,    // req_type[0]
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       i_out_data,   // min_cliques[4:0], zeros[7:5]
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    logic [SUBSET_W-1:0] adj_rows [MAX_VERTICES];
    logic [COST_W-1:0]   cost_memo [1 << MAX_VERTICES];
    logic [CNT_W-1:0]    vcount;
    logic [COST_W-1:0]   cover_queue [$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // fewest cliques covering vertices 0 .. count-1 of the current graph
    function automatic logic [COST_W-1:0] fewest_cliques(input logic [CNT_W-1:0] count);
        int unsigned n, full, s, sub, low, rest, v, best, sum;
        n = count;
        if (n < 1) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        full = (1 << n) - 1;

        // clique marks: lowest vertex must see the rest, and the rest must be a clique
        cost_memo[0] = COST_ONE;
        for (s = 1; s <= full; s++) begin
            v = 0;
            while (s[v] == 1'b0) v++;
            rest = s & (s - 1);
            if (cost_memo[rest] == COST_ONE &&
                (adj_rows[v] & rest[SUBSET_W-1:0]) == rest[SUBSET_W-1:0])
                cost_memo[s] = COST_ONE;
            else
                cost_memo[s] = UNBOUNDED;
        end

        // best split, each unordered pair once via the side holding the lowest vertex
        for (s = 1; s <= full; s++) begin
            best = cost_memo[s];
            if (best == COST_ONE) continue;
            low = s & (~s + 1);
            sub = (s - 1) & s;
            while (sub != 0) begin
                if ((sub & low) != 0) begin
                    sum = cost_memo[sub] + cost_memo[s ^ sub];
                    if (sum >= UNBOUNDED) sum = UNBOUNDED;
                    if (sum < best) best = sum;
                end
                sub = (sub - 1) & s;
            end
            cost_memo[s] = best[COST_W-1:0];
        end
        return cost_memo[full];
    endfunction

    always @(posedge i_clk) begin
        logic [VIDX_W-1:0] va, vb;
        logic [COST_W-1:0] want;
        if (!i_rst_n) begin
            foreach (adj_rows[r]) adj_rows[r] = '0;
            vcount = VCNT_RESET;
            cover_queue.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) vcount = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                va = i_in_data[VIDX_W-1:0];
                vb = i_in_data[2*VIDX_W-1:VIDX_W];
                if (i_in_user == REQ_SOLVE) begin
                    cover_queue.push_back(fewest_cliques(vcount));
                    foreach (adj_rows[r]) adj_rows[r] = '0;
                end else if (va != vb) begin
                    adj_rows[va][vb] = 1'b1;
                    adj_rows[vb][va] = 1'b1;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (cover_queue.size() == 0) begin
                    note_mismatch("answer word with none pending", i_out_data, 0);
                end else begin
                    want = cover_queue.pop_front();
                    if (i_out_data[COST_W-1:0] != want)
                        note_mismatch("min_cliques", i_out_data[COST_W-1:0], want);
                end
                if (i_out_data[7:COST_W] != '0)
                    note_mismatch("tdata padding", i_out_data[7:COST_W], 0);
            end
            o_pending <= cover_queue.size();
        end
    end

endmodule

// ----- bench/tb_min_clique_cover_subset_dp.sv -----
`timescale 1ns / 1ps

module tb_min_clique_cover_subset_dp;
    import mccs_pkg::*;

    localparam int RAND_WORDS  = 1900;
    localparam int SETTLE      = 8;            // cycles after the last answer before a count write
    localparam int TAIL        = 64;
    // every word a nine-vertex solve, plus two full-size clique solves
    localparam int CYCLE_LIMIT = 100_000_000;

    // shapes of the graph built before a solve
    typedef enum int {G_SPARSE, G_DENSE, G_GROUPS, G_EMPTY, G_NOISE, G_FULL} t_graph_shape;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;

    // edge / solve words toward the block
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [7:0]        in_data   = '0;        // vertex_a[3:0], vertex_b[7:4]
    logic              in_user   = REQ_EDGE;  // req_type[0]

    // answer words from the block
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        out_data;              // min_cliques[4:0], zeros[7:5]

    // vertex count register
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data  = '0;

    // stretches with no idling on either side
    logic              quiet_in  = 1'b0;
    logic              quiet_out = 1'b0;

    int                words_sent  = 0;
    int                cycle_count = 0;
    int                stall_left  = 0;
    int                pending;
    int                fail_count;

    min_clique_cover_subset_dp u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_user),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    mccs_cover_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_in_user    (in_user),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the block hangs or loses an answer
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // small counts keep the split search short; a few reach nine vertices
    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 5);
        if (r < 92) return $urandom_range(6, 7);
        return $urandom_range(8, 9);
    endfunction

    function automatic t_graph_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return G_SPARSE;
        if (r < 50) return G_DENSE;
        if (r < 80) return G_GROUPS;
        if (r < 88) return G_EMPTY;
        return G_NOISE;
    endfunction

    // answer side: random stalls, independent of what the block is doing
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!quiet_out && $urandom_range(0, 99) < 25) begin
                out_ready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // one word, optional gap first; returns in the step of the handshake with valid still high
    task automatic send_word(input logic req, input logic [3:0] va, input logic [3:0] vb);
        int gap;
        gap = (!quiet_in && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_user  <= req;
        in_data  <= {vb, va};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        // self loops are dropped by the block and do not count
        if (req == REQ_SOLVE || va != vb) words_sent++;
    endtask

    // drop valid, wait for every answer, then let an edge word in flight finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // build a graph on n vertices in random word order, then usually solve
    task automatic run_graph(input int n, input t_graph_shape shape);
        logic [7:0] pairs [$];
        logic [7:0] swap;
        int         grp [MAX_VERTICES];
        int         groups, i, j, k, r;
        logic       take;
        groups = $urandom_range(1, n);
        for (i = 0; i < n; i++) grp[i] = $urandom_range(0, groups - 1);
        for (i = 0; i < n; i++) begin
            for (j = i + 1; j < n; j++) begin
                case (shape)
                    G_SPARSE: take = $urandom_range(0, 99) < 25;
                    G_DENSE:  take = $urandom_range(0, 99) < 85;
                    // disjoint cliques with a few cross edges
                    G_GROUPS: take = grp[i] == grp[j] || $urandom_range(0, 99) < 8;
                    G_FULL:   take = 1'b1;
                    default:  take = 1'b0;
                endcase
                if (take)
                    pairs.push_back($urandom_range(0, 1) ? {4'(i), 4'(j)} : {4'(j), 4'(i)});
            end
        end

        if (shape == G_NOISE) begin
            // arbitrary endpoints anywhere in the field range, self loops included
            repeat ($urandom_range(1, 12)) pairs.push_back(8'($urandom));
        end else if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(0, 2);
                k = $urandom_range(0, n - 1);
                if (r == 1 && n < MAX_VERTICES)
                    // endpoint past the count: stored but outside the solve
                    pairs.push_back({4'($urandom_range(n, MAX_VERTICES - 1)), 4'(k)});
                else if (r == 2 && pairs.size() > 0)
                    pairs.push_back(pairs[$urandom_range(0, pairs.size() - 1)]);
                else
                    pairs.push_back({4'(k), 4'(k)});
            end
        end

        for (k = pairs.size() - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            swap     = pairs[k];
            pairs[k] = pairs[j];
            pairs[j] = swap;
        end
        foreach (pairs[p]) send_word(REQ_EDGE, pairs[p][3:0], pairs[p][7:4]);

        // now and then the edges carry over, or a second solve sees empty rows
        r = $urandom_range(0, 99);
        if (shape == G_FULL || r >= 5) send_word(REQ_SOLVE, 4'($urandom), 4'($urandom));
        if (shape != G_FULL && r >= 90) send_word(REQ_SOLVE, 4'($urandom), 4'($urandom));
    endtask

    initial begin
        int               n;
        logic [CNT_W-1:0] value;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count still at its reset value of sixteen; only a full clique keeps that solve short
        run_graph(MAX_VERTICES, G_FULL);

        // count zero behaves as one vertex; self loop and stray endpoint change nothing
        write_vertex_count(5'd0);
        send_word(REQ_EDGE, 4'd15, 4'd15);
        send_word(REQ_EDGE, 4'd0, 4'd15);
        send_word(REQ_SOLVE, 4'd0, 4'd0);

        write_vertex_count(5'd1);
        send_word(REQ_SOLVE, 4'd15, 4'd15);

        // path on three vertices needs two cliques
        write_vertex_count(5'd3);
        send_word(REQ_EDGE, 4'd0, 4'd1);
        send_word(REQ_EDGE, 4'd2, 4'd1);
        send_word(REQ_SOLVE, 4'd3, 4'd12);

        // two disjoint edges plus bits past the count, then a solve on cleared rows
        write_vertex_count(5'd4);
        send_word(REQ_EDGE, 4'd0, 4'd1);
        send_word(REQ_EDGE, 4'd2, 4'd3);
        send_word(REQ_EDGE, 4'd3, 4'd3);
        send_word(REQ_EDGE, 4'd15, 4'd14);
        send_word(REQ_EDGE, 4'd1, 4'd15);
        send_word(REQ_SOLVE, 4'd0, 4'd0);
        send_word(REQ_SOLVE, 4'd15, 4'd15);

        // triangle and a separate edge, one edge repeated
        write_vertex_count(5'd5);
        send_word(REQ_EDGE, 4'd0, 4'd1);
        send_word(REQ_EDGE, 4'd1, 4'd2);
        send_word(REQ_EDGE, 4'd2, 4'd0);
        send_word(REQ_EDGE, 4'd0, 4'd1);
        send_word(REQ_EDGE, 4'd3, 4'd4);
        send_word(REQ_EDGE, 4'd4, 4'd4);
        send_word(REQ_SOLVE, 4'd5, 4'd10);

        // count above the maximum clamps to sixteen
        write_vertex_count(5'd31);
        run_graph(MAX_VERTICES, G_FULL);

        // random phases: new count, idling mode, then a few graphs each
        while (words_sent < RAND_WORDS) begin
            n     = pick_count();
            value = CNT_W'(n);
            if (n == 1 && $urandom_range(0, 1)) value = '0;
            write_vertex_count(value);
            quiet_in  = $urandom_range(0, 5) == 0;
            quiet_out <= $urandom_range(0, 5) == 0;
            repeat ($urandom_range(1, 5)) run_graph(n, pick_shape());
        end

        wait_drained();
        repeat (TAIL) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/mccs_pkg.sv
design/mccs_ctrl.sv
design/mccs_dp.sv
design/min_clique_cover_subset_dp.sv
bench/mccs_cover_checker.sv
bench/tb_min_clique_cover_subset_dp.sv
